/* hdl/cvd_pkg.sv */
// Shared types for the convex polygon diameter block: datapath operation
// codes and the command/status structs between controller and datapath.
// No dependencies.
package cvd_pkg;

   // Default vertex store depth
   localparam int MAX_VERTICES_DEF = 1024;

   // Coordinate and result widths fixed by the interface
   localparam int COORD_W = 31;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int DIST_W  = 63;

   // Operations of the shared multiply pipeline
   typedef enum logic [2:0] {
      OP_AREA_P  = 3'd0,   // |(B - A) x (P - B)|
      OP_AREA_Q  = 3'd1,   // |(B - A) x (Q - B)|
      OP_DIST_AB = 3'd2,   // |A - B|^2
      OP_DIST_AP = 3'd3,   // |A - P|^2
      OP_DIST_BP = 3'd4    // |B - P|^2
   } op_type;

   // Controller to datapath
   typedef struct packed {
      logic   issue;       // start one operation in the pipeline
      op_type op;
      logic   mem_we;      // store the incoming vertex
      logic   load_ab;     // A, B <= read ports 0, 1
      logic   load_pq;     // P, Q <= read ports 0, 1
      logic   load_q;      // Q <= read port 0
      logic   shift_ab;    // A <= B, B <= read port 0
      logic   advance;     // P <= Q, area_p <= area_q
      logic   clear_best;  // restart the running maximum
      logic   emit;        // load the result register
      logic   ovf;         // overflow flag for the result
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic busy;          // an operation is still in the pipeline
      logic p_le_q;        // area at P <= area at Q
      logic rsp_free;      // result register can take a new result
   } sts_type;

endpackage

/* hdl/convex_polygon_diameter.sv */
// Convex polygon diameter: loads one vertex per cycle; the last vertex starts a
// rotating-calipers walk (pairwise distances below four vertices) over one shared
// four-stage multiply pipeline that drains before every decision.
// Sync active-high reset: empty store count, controller in load, no result.
// Depends on cvd_pkg, cvd_ctrl, cvd_dp.
module convex_polygon_diameter #(
   parameter int MAX_VERTICES = cvd_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [cvd_pkg::COORD_W-1:0]  req_vertex_x,
   input  logic signed [cvd_pkg::COORD_W-1:0]  req_vertex_y,
   input  logic                                req_last_vertex,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cvd_pkg::DIST_W-1:0]          rsp_diameter_squared,
   output logic                                rsp_overflow_flag
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 2);

   cvd_pkg::cmd_type   cmd;
   cvd_pkg::sts_type   sts;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr0;
   logic [IDX_W-1:0]   rd_addr1;

   cvd_ctrl #(
      .MAX_VERTICES (MAX_VERTICES),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_vertex (req_last_vertex),
      .req_ready       (req_ready),
      .cmd             (cmd),
      .sts             (sts),
      .wr_addr         (wr_addr),
      .rd_addr0        (rd_addr0),
      .rd_addr1        (rd_addr1)
   );

   cvd_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .IDX_W        (IDX_W)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .wr_addr              (wr_addr),
      .rd_addr0             (rd_addr0),
      .rd_addr1             (rd_addr1),
      .req_vertex_x         (req_vertex_x),
      .req_vertex_y         (req_vertex_y),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_diameter_squared (rsp_diameter_squared),
      .rsp_overflow_flag    (rsp_overflow_flag)
   );

endmodule

/* hdl/cvd_ctrl.sv */
// Controller of the convex polygon diameter block: vertex loading, store
// addressing and the rotating-calipers sequence.
// Depends on cvd_pkg.
module cvd_ctrl #(
   parameter int MAX_VERTICES = cvd_pkg::MAX_VERTICES_DEF,
   parameter int IDX_W        = $clog2(MAX_VERTICES),
   parameter int CNT_W        = $clog2(MAX_VERTICES + 2)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_vertex,
   output logic                 req_ready,
   output cvd_pkg::cmd_type     cmd,
   input  cvd_pkg::sts_type     sts,
   output logic [IDX_W-1:0]     wr_addr,
   output logic [IDX_W-1:0]     rd_addr0,
   output logic [IDX_W-1:0]     rd_addr1
);

   typedef enum logic [18:0] {
      ST_LOAD       = 19'b0000000000000000001,
      ST_FETCH      = 19'b0000000000000000010,
      ST_CAP_AB     = 19'b0000000000000000100,
      ST_CAP_PQ     = 19'b0000000000000001000,
      ST_ISSUE_AB   = 19'b0000000000000010000,
      ST_ISSUE_AP   = 19'b0000000000000100000,
      ST_ISSUE_BP   = 19'b0000000000001000000,
      ST_WAIT_SMALL = 19'b0000000000010000000,
      ST_AREA_P     = 19'b0000000000100000000,
      ST_AREA_Q     = 19'b0000000001000000000,
      ST_WAIT_AREA  = 19'b0000000010000000000,
      ST_DECIDE     = 19'b0000000100000000000,
      ST_CAP_Q      = 19'b0000001000000000000,
      ST_DIST_BP    = 19'b0000010000000000000,
      ST_DIST_AP    = 19'b0000100000000000000,
      ST_WAIT_DIST  = 19'b0001000000000000000,
      ST_NEXT_EDGE  = 19'b0010000000000000000,
      ST_CAP_B      = 19'b0100000000000000000,
      ST_FINISH     = 19'b1000000000000000000
   } state_type;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              ovf_ff, ovf_in;
   logic [IDX_W-1:0]  edge_ff, edge_in;
   logic [IDX_W-1:0]  b_idx_ff, b_idx_in;
   logic [IDX_W-1:0]  p_idx_ff, p_idx_in;
   logic [IDX_W-1:0]  q_idx_ff, q_idx_in;
   logic [IDX_W-1:0]  steps_ff, steps_in;
   logic              room;
   logic [CNT_W-1:0]  n_new;

   // Next index around a polygon of n vertices
   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] nx;
      nx = CNT_W'(idx) + CNT_W'(1);
      return (nx >= n) ? '0 : nx[IDX_W-1:0];
   endfunction

   assign room    = count_ff < MAX_CNT;
   assign n_new   = room ? count_ff + CNT_W'(1) : MAX_CNT;
   assign wr_addr = count_ff[IDX_W-1:0];

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      n_in      = n_ff;
      ovf_in    = ovf_ff;
      edge_in   = edge_ff;
      b_idx_in  = b_idx_ff;
      p_idx_in  = p_idx_ff;
      q_idx_in  = q_idx_ff;
      steps_in  = steps_ff;
      req_ready = 1'b0;
      rd_addr0  = '0;
      rd_addr1  = '0;
      cmd       = '0;
      cmd.op    = cvd_pkg::OP_AREA_P;
      cmd.ovf   = ovf_ff;

      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.mem_we = room;
               count_in   = room ? count_ff + CNT_W'(1) : MAX_CNT + CNT_W'(1);
               if (req_last_vertex) begin
                  cmd.clear_best = 1'b1;
                  count_in       = '0;
                  n_in           = n_new;
                  ovf_in         = !room;
                  p_idx_in       = IDX_W'(2);
                  q_idx_in       = wrap_inc(IDX_W'(2), n_new);
                  state_in       = (n_new >= CNT_W'(2)) ? ST_FETCH : ST_FINISH;
               end
            end
         end
         ST_FETCH: begin
            rd_addr0 = '0;
            rd_addr1 = IDX_W'(1);
            state_in = ST_CAP_AB;
         end
         ST_CAP_AB: begin
            cmd.load_ab = 1'b1;
            rd_addr0    = p_idx_ff;
            rd_addr1    = q_idx_ff;
            state_in    = ST_CAP_PQ;
         end
         ST_CAP_PQ: begin
            cmd.load_pq = 1'b1;
            edge_in     = '0;
            b_idx_in    = IDX_W'(1);
            steps_in    = '0;
            state_in    = (n_ff <= CNT_W'(3)) ? ST_ISSUE_AB : ST_AREA_P;
         end
         // Two or three vertices: pairwise distances
         ST_ISSUE_AB: begin
            cmd.issue = 1'b1;
            cmd.op    = cvd_pkg::OP_DIST_AB;
            state_in  = (n_ff == CNT_W'(2)) ? ST_WAIT_SMALL : ST_ISSUE_AP;
         end
         ST_ISSUE_AP: begin
            cmd.issue = 1'b1;
            cmd.op    = cvd_pkg::OP_DIST_AP;
            state_in  = ST_ISSUE_BP;
         end
         ST_ISSUE_BP: begin
            cmd.issue = 1'b1;
            cmd.op    = cvd_pkg::OP_DIST_BP;
            state_in  = ST_WAIT_SMALL;
         end
         ST_WAIT_SMALL: begin
            if (!sts.busy) begin
               state_in = ST_FINISH;
            end
         end
         // Calipers walk
         ST_AREA_P: begin
            cmd.issue = 1'b1;
            cmd.op    = cvd_pkg::OP_AREA_P;
            state_in  = ST_AREA_Q;
         end
         ST_AREA_Q: begin
            cmd.issue = 1'b1;
            cmd.op    = cvd_pkg::OP_AREA_Q;
            state_in  = ST_WAIT_AREA;
         end
         ST_WAIT_AREA: begin
            if (!sts.busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if ((CNT_W'(steps_ff) < n_ff - CNT_W'(1)) && sts.p_le_q) begin
               cmd.advance = 1'b1;
               p_idx_in    = q_idx_ff;
               q_idx_in    = wrap_inc(q_idx_ff, n_ff);
               rd_addr0    = wrap_inc(q_idx_ff, n_ff);
               steps_in    = steps_ff + IDX_W'(1);
               state_in    = ST_CAP_Q;
            end else begin
               state_in = ST_DIST_BP;
            end
         end
         ST_CAP_Q: begin
            cmd.load_q = 1'b1;
            state_in   = ST_AREA_Q;
         end
         ST_DIST_BP: begin
            cmd.issue = 1'b1;
            cmd.op    = cvd_pkg::OP_DIST_BP;
            state_in  = ST_DIST_AP;
         end
         ST_DIST_AP: begin
            cmd.issue = 1'b1;
            cmd.op    = cvd_pkg::OP_DIST_AP;
            state_in  = ST_WAIT_DIST;
         end
         ST_WAIT_DIST: begin
            if (!sts.busy) begin
               state_in = ST_NEXT_EDGE;
            end
         end
         ST_NEXT_EDGE: begin
            if (CNT_W'(edge_ff) + CNT_W'(1) == n_ff) begin
               state_in = ST_FINISH;
            end else begin
               edge_in  = edge_ff + IDX_W'(1);
               b_idx_in = wrap_inc(b_idx_ff, n_ff);
               rd_addr0 = wrap_inc(b_idx_ff, n_ff);
               steps_in = '0;
               state_in = ST_CAP_B;
            end
         end
         ST_CAP_B: begin
            cmd.shift_ab = 1'b1;
            state_in     = ST_AREA_P;
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         n_ff     <= '0;
         ovf_ff   <= 1'b0;
         edge_ff  <= '0;
         b_idx_ff <= '0;
         p_idx_ff <= '0;
         q_idx_ff <= '0;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         n_ff     <= n_in;
         ovf_ff   <= ovf_in;
         edge_ff  <= edge_in;
         b_idx_ff <= b_idx_in;
         p_idx_ff <= p_idx_in;
         q_idx_ff <= q_idx_in;
         steps_ff <= steps_in;
      end
   end

endmodule

/* hdl/cvd_dp.sv */
// Datapath of the convex polygon diameter block: vertex store, working
// vertex registers, four-stage multiply pipeline, running maximum, result.
// Depends on cvd_pkg.
module cvd_dp #(
   parameter int MAX_VERTICES = cvd_pkg::MAX_VERTICES_DEF,
   parameter int IDX_W        = $clog2(MAX_VERTICES)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cvd_pkg::cmd_type                    cmd,
   output cvd_pkg::sts_type                    sts,
   input  logic [IDX_W-1:0]                    wr_addr,
   input  logic [IDX_W-1:0]                    rd_addr0,
   input  logic [IDX_W-1:0]                    rd_addr1,
   input  logic signed [cvd_pkg::COORD_W-1:0]  req_vertex_x,
   input  logic signed [cvd_pkg::COORD_W-1:0]  req_vertex_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cvd_pkg::DIST_W-1:0]          rsp_diameter_squared,
   output logic                                rsp_overflow_flag
);

   localparam int CW = cvd_pkg::COORD_W;
   localparam int DW = cvd_pkg::DIFF_W;
   localparam int PW = cvd_pkg::PROD_W;
   localparam int SW = cvd_pkg::PROD_W + 1;
   localparam int RW = cvd_pkg::DIST_W;

   // Vertex store
   logic signed [CW-1:0] x_mem [MAX_VERTICES];
   logic signed [CW-1:0] y_mem [MAX_VERTICES];
   logic signed [CW-1:0] rd0x_ff, rd0y_ff, rd1x_ff, rd1y_ff;

   // Working vertices: edge A->B, antipode P and its successor Q
   logic signed [CW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [CW-1:0] px_ff, py_ff, qx_ff, qy_ff;

   // Pipeline
   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   cvd_pkg::op_type      op1_ff, op2_ff, op3_ff, op4_ff;
   logic signed [DW-1:0] m0a_in, m0b_in, m1a_in, m1b_in;
   logic signed [DW-1:0] m0a_ff, m0b_ff, m1a_ff, m1b_ff;
   logic signed [PW-1:0] p0_ff, p1_ff;
   logic signed [SW-1:0] s_in, s_ff;
   logic signed [SW-1:0] s_neg;
   logic [RW-1:0]        mag_ff;

   logic [RW-1:0]        area_p_ff, area_q_ff;
   logic [RW-1:0]        best_ff;
   logic                 rsp_valid_ff;
   logic [RW-1:0]        rsp_dist_ff;
   logic                 rsp_ovf_ff;

   function automatic logic signed [DW-1:0] sub_ext(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
      return DW'(a) - DW'(b);
   endfunction

   // Store write and two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         x_mem[wr_addr] <= req_vertex_x;
         y_mem[wr_addr] <= req_vertex_y;
      end
      rd0x_ff <= x_mem[rd_addr0];
      rd0y_ff <= y_mem[rd_addr0];
      rd1x_ff <= x_mem[rd_addr1];
      rd1y_ff <= y_mem[rd_addr1];
   end

   // Working vertex registers
   always_ff @(posedge clock) begin
      if (cmd.load_ab) begin
         ax_ff <= rd0x_ff;
         ay_ff <= rd0y_ff;
         bx_ff <= rd1x_ff;
         by_ff <= rd1y_ff;
      end else if (cmd.shift_ab) begin
         ax_ff <= bx_ff;
         ay_ff <= by_ff;
         bx_ff <= rd0x_ff;
         by_ff <= rd0y_ff;
      end
      if (cmd.load_pq) begin
         px_ff <= rd0x_ff;
         py_ff <= rd0y_ff;
         qx_ff <= rd1x_ff;
         qy_ff <= rd1y_ff;
      end else if (cmd.advance) begin
         px_ff <= qx_ff;
         py_ff <= qy_ff;
      end else if (cmd.load_q) begin
         qx_ff <= rd0x_ff;
         qy_ff <= rd0y_ff;
      end
   end

   // Operand stage: coordinate differences
   always_comb begin
      unique case (cmd.op)
         cvd_pkg::OP_AREA_P: begin
            m0a_in = sub_ext(bx_ff, ax_ff);
            m0b_in = sub_ext(py_ff, by_ff);
            m1a_in = sub_ext(by_ff, ay_ff);
            m1b_in = sub_ext(px_ff, bx_ff);
         end
         cvd_pkg::OP_AREA_Q: begin
            m0a_in = sub_ext(bx_ff, ax_ff);
            m0b_in = sub_ext(qy_ff, by_ff);
            m1a_in = sub_ext(by_ff, ay_ff);
            m1b_in = sub_ext(qx_ff, bx_ff);
         end
         cvd_pkg::OP_DIST_AB: begin
            m0a_in = sub_ext(ax_ff, bx_ff);
            m0b_in = m0a_in;
            m1a_in = sub_ext(ay_ff, by_ff);
            m1b_in = m1a_in;
         end
         cvd_pkg::OP_DIST_AP: begin
            m0a_in = sub_ext(ax_ff, px_ff);
            m0b_in = m0a_in;
            m1a_in = sub_ext(ay_ff, py_ff);
            m1b_in = m1a_in;
         end
         cvd_pkg::OP_DIST_BP: begin
            m0a_in = sub_ext(bx_ff, px_ff);
            m0b_in = m0a_in;
            m1a_in = sub_ext(by_ff, py_ff);
            m1b_in = m1a_in;
         end
         default: begin
            m0a_in = '0;
            m0b_in = '0;
            m1a_in = '0;
            m1b_in = '0;
         end
      endcase
   end

   // Combine: cross product for areas, sum of squares for distances
   assign s_in  = (op2_ff == cvd_pkg::OP_AREA_P || op2_ff == cvd_pkg::OP_AREA_Q)
                ? SW'(p0_ff) - SW'(p1_ff)
                : SW'(p0_ff) + SW'(p1_ff);
   assign s_neg = -s_ff;

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Pipeline payload: operation tags, operands, products, combined sum, magnitude
   always_ff @(posedge clock) begin
      op1_ff <= cmd.op;
      op2_ff <= op1_ff;
      op3_ff <= op2_ff;
      op4_ff <= op3_ff;
      m0a_ff <= m0a_in;
      m0b_ff <= m0b_in;
      m1a_ff <= m1a_in;
      m1b_ff <= m1b_in;
      p0_ff  <= m0a_ff * m0b_ff;
      p1_ff  <= m1a_ff * m1b_ff;
      s_ff   <= s_in;
      mag_ff <= s_ff[SW-1] ? s_neg[RW-1:0] : s_ff[RW-1:0];
   end

   // Write back: areas and running maximum
   always_ff @(posedge clock) begin
      if (cmd.clear_best) begin
         best_ff <= '0;
      end else if (v4_ff && op4_ff != cvd_pkg::OP_AREA_P
                         && op4_ff != cvd_pkg::OP_AREA_Q) begin
         if (mag_ff > best_ff) begin
            best_ff <= mag_ff;
         end
      end
      if (cmd.advance) begin
         area_p_ff <= area_q_ff;
      end else if (v4_ff && op4_ff == cvd_pkg::OP_AREA_P) begin
         area_p_ff <= mag_ff;
      end
      if (v4_ff && op4_ff == cvd_pkg::OP_AREA_Q) begin
         area_q_ff <= mag_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_dist_ff <= best_ff;
         rsp_ovf_ff  <= cmd.ovf;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_diameter_squared = rsp_dist_ff;
   assign rsp_overflow_flag    = rsp_ovf_ff;

   assign sts.busy     = v1_ff | v2_ff | v3_ff | v4_ff;
   assign sts.p_le_q   = area_p_ff <= area_q_ff;
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

endmodule

/* hdl/cvd_checker.sv */
// Port-level checks for the convex polygon diameter block, bound to the top.
// Depends on convex_polygon_diameter and cvd_pkg.
module cvd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_last_vertex,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [cvd_pkg::DIST_W-1:0]  rsp_diameter_squared,
   input logic                        rsp_overflow_flag
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_diameter_squared)
                                  && $stable(rsp_overflow_flag))
      else $error("result changed while stalled");

   // Closing a polygon stops loading
   a_last_stops_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_vertex |=> !req_ready)
      else $error("input still ready after last vertex");

   // A new result comes out of a compute phase, never out of loading
   a_rsp_after_compute: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while loading");

   // Reset leaves an empty, loading block
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind convex_polygon_diameter cvd_checker u_cvd_checker (.*);

/* tb/diameter_checker.sv */
// Watches the vertex and diameter channels, predicts each polygon's squared
// diameter with its own rotating-calipers walk and compares every transfer.
// Depends on cvd_pkg for widths and the default store depth.
module diameter_checker #(
   parameter int MAX_VERTICES = cvd_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [cvd_pkg::COORD_W-1:0]  req_vertex_x,
   input  logic signed [cvd_pkg::COORD_W-1:0]  req_vertex_y,
   input  logic                                req_last_vertex,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [cvd_pkg::DIST_W-1:0]          rsp_diameter_squared,
   input  logic                                rsp_overflow_flag,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [cvd_pkg::DIST_W-1:0] diameter_sq;
      logic                       overflow;
   } diameter_result_type;

   // Expected results, oldest first
   diameter_result_type expected_diameters[$];

   // Vertices of the polygon being loaded, sign-extended
   longint poly_x[MAX_VERTICES];
   longint poly_y[MAX_VERTICES];
   int     loaded = 0;
   int     failures = 0;
   int     checked = 0;

   diameter_result_type predicted;
   diameter_result_type oldest;
   int                  used;

   // |(b - a) x (c - b)|, twice the triangle area
   function automatic longint unsigned area_mag(int a, int b, int c);
      longint ux, uy, vx, vy, cr;
      ux = poly_x[b] - poly_x[a];
      uy = poly_y[b] - poly_y[a];
      vx = poly_x[c] - poly_x[b];
      vy = poly_y[c] - poly_y[b];
      cr = ux * vy - uy * vx;
      return longint'(cr < 0 ? -cr : cr);
   endfunction

   function automatic longint unsigned span_sq(int p, int q);
      longint dx, dy;
      dx = poly_x[p] - poly_x[q];
      dy = poly_y[p] - poly_y[q];
      return dx * dx + dy * dy;
   endfunction

   // Greatest squared distance: pairwise up to three vertices, calipers walk above.
   // On degenerate input the antipode moves at most n - 1 times per edge.
   function automatic longint unsigned calipers_diameter(int n);
      longint unsigned best, d;
      int              ap, a, b, steps;
      best = 0;
      if (n == 2) begin
         best = span_sq(0, 1);
      end else if (n == 3) begin
         best = span_sq(0, 1);
         d = span_sq(0, 2);
         if (d > best) best = d;
         d = span_sq(1, 2);
         if (d > best) best = d;
      end else if (n >= 4) begin
         ap = 2;
         for (int e = 0; e < n; e++) begin
            a = e;
            b = (e + 1) % n;
            steps = 0;
            while (steps < n - 1 && area_mag(a, b, ap) <= area_mag(a, b, (ap + 1) % n)) begin
               ap = (ap + 1) % n;
               steps++;
            end
            d = span_sq(b, ap);
            if (d > best) best = d;
            d = span_sq(a, ap);
            if (d > best) best = d;
         end
      end
      return best;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         loaded = 0;
         expected_diameters.delete();
      end else begin
         // vertex transfer: store, and on the last one predict the result
         if (req_valid && req_ready) begin
            if (loaded < MAX_VERTICES) begin
               poly_x[loaded] = longint'(req_vertex_x);
               poly_y[loaded] = longint'(req_vertex_y);
               loaded++;
            end else begin
               loaded = MAX_VERTICES + 1;
            end
            if (req_last_vertex) begin
               predicted.overflow = (loaded > MAX_VERTICES);
               used = predicted.overflow ? MAX_VERTICES : loaded;
               predicted.diameter_sq = cvd_pkg::DIST_W'(calipers_diameter(used));
               expected_diameters.push_back(predicted);
               loaded = 0;
            end
         end

         // diameter transfer: compare with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_diameters.size() == 0) begin
               $display("%0t: unexpected diameter transfer: expected none, got %0d ovf %0b",
                        $time, rsp_diameter_squared, rsp_overflow_flag);
               failures++;
            end else begin
               oldest = expected_diameters.pop_front();
               if (rsp_diameter_squared !== oldest.diameter_sq) begin
                  $display("%0t: diameter_squared mismatch: expected %0d, got %0d",
                           $time, oldest.diameter_sq, rsp_diameter_squared);
                  failures++;
               end
               if (rsp_overflow_flag !== oldest.overflow) begin
                  $display("%0t: overflow_flag mismatch: expected %0b, got %0b",
                           $time, oldest.overflow, rsp_overflow_flag);
                  failures++;
               end
               checked++;
            end
         end
      end
      fail_count    <= failures;
      pending_count <= expected_diameters.size();
      checked_count <= checked;
   end

endmodule

/* tb/convex_polygon_diameter_tb.sv */
// Top of the diameter testbench: clock, reset, vertex stimulus and random
// back-pressure, plus the verdict. Depends on cvd_pkg, diameter_checker and the block.
module convex_polygon_diameter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  COORD_W       = cvd_pkg::COORD_W;
   localparam int  DIST_W        = cvd_pkg::DIST_W;
   localparam int  CYCLE_LIMIT   = 1_000_000;
   localparam int  SETTLE_CYCLES = 64;
   localparam int  RANDOM_ITEMS  = 700;
   localparam real TWO_PI        = 6.283185307179586;
   localparam logic signed [COORD_W-1:0] COORD_MIN = COORD_W'(-(2 ** (COORD_W - 1)));
   localparam logic signed [COORD_W-1:0] COORD_MAX = COORD_W'(2 ** (COORD_W - 1) - 1);

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [COORD_W-1:0]  req_vertex_x = '0;
   logic signed [COORD_W-1:0]  req_vertex_y = '0;
   logic                       req_last_vertex = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [DIST_W-1:0]          rsp_diameter_squared;
   logic                       rsp_overflow_flag;

   int fail_count;
   int pending_count;
   int checked_count;
   int cycle_count    = 0;
   int send_gap_pct   = 19;
   int rsp_stall_pct  = 52;
   int vertices_sent  = 0;
   int polygons_sent  = 0;

   convex_polygon_diameter dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_vertex_x         (req_vertex_x),
      .req_vertex_y         (req_vertex_y),
      .req_last_vertex      (req_last_vertex),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_diameter_squared (rsp_diameter_squared),
      .rsp_overflow_flag    (rsp_overflow_flag)
   );

   diameter_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_vertex_x         (req_vertex_x),
      .req_vertex_y         (req_vertex_y),
      .req_last_vertex      (req_last_vertex),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_diameter_squared (rsp_diameter_squared),
      .rsp_overflow_flag    (rsp_overflow_flag),
      .fail_count           (fail_count),
      .pending_count        (pending_count),
      .checked_count        (checked_count)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped by watchdog after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Random back-pressure on the diameter channel
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   function automatic logic signed [COORD_W-1:0] rand_coord();
      logic [31:0] r;
      r = $urandom();
      return r[COORD_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(real v);
      longint p;
      p = longint'(v);
      if (p > longint'(COORD_MAX)) p = longint'(COORD_MAX);
      if (p < longint'(COORD_MIN)) p = longint'(COORD_MIN);
      return p[COORD_W-1:0];
   endfunction

   // One vertex transfer; called in the step of a rising edge, returns at the
   // edge that took it. Ready is looked at on the falling edge.
   task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic last);
      logic taken;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_vertex_x    <= x;
      req_vertex_y    <= y;
      req_last_vertex <= last;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      vertices_sent++;
      if (last) polygons_sent++;
   endtask

   // Convex polygon on a rotated ellipse; vertices past shape_n repeat the shape.
   // A total_n of 0 means one pass over the shape.
   task automatic send_ellipse(int shape_n, int total_n, int radius_log2);
      longint rmax, room, cx, cy;
      real    rx, ry, rot, phase, dir, ang, ex, ey;
      int     count;
      count = (total_n == 0) ? shape_n : total_n;
      rmax  = longint'(1) << radius_log2;
      room  = longint'(COORD_MAX) - 2 * rmax;
      cx    = longint'($urandom_range(0, 32'(2 * room))) - room;
      cy    = longint'($urandom_range(0, 32'(2 * room))) - room;
      rx    = $urandom_range(1, 32'(rmax));
      ry    = $urandom_range(1, 32'(rmax));
      rot   = TWO_PI * $urandom_range(0, 999) / 1000.0;
      phase = TWO_PI * $urandom_range(0, 999) / 1000.0;
      dir   = $urandom_range(0, 1) ? 1.0 : -1.0;
      for (int k = 0; k < count; k++) begin
         ang = phase + dir * TWO_PI * (k % shape_n) / shape_n;
         ex  = rx * $cos(ang);
         ey  = ry * $sin(ang);
         send_vertex(clamp_coord(cx + ex * $cos(rot) - ey * $sin(rot)),
                     clamp_coord(cy + ex * $sin(rot) + ey * $cos(rot)),
                     k == count - 1);
      end
   endtask

   // Arbitrary points, which need not be convex for four and more
   task automatic send_scatter(int n);
      for (int k = 0; k < n; k++)
         send_vertex(rand_coord(), rand_coord(), k == n - 1);
   endtask

   // Points on one line in random order, or all equal when the step is zero
   task automatic send_collinear(int n);
      longint bx, by, sx, sy, t;
      bx = longint'($urandom_range(0, 1 << 30)) - (1 << 29);
      by = longint'($urandom_range(0, 1 << 30)) - (1 << 29);
      sx = $urandom_range(0, 3) == 0 ? 0 : longint'($urandom_range(0, 2000)) - 1000;
      sy = $urandom_range(0, 3) == 0 ? 0 : longint'($urandom_range(0, 2000)) - 1000;
      for (int k = 0; k < n; k++) begin
         t = $urandom_range(0, 16);
         send_vertex(COORD_W'(bx + t * sx), COORD_W'(by + t * sy), k == n - 1);
      end
   endtask

   // Mostly convex polygons of small size, the rest small, scattered, degenerate or large convex
   task automatic send_random_polygons(int quota);
      int start, pick;
      start = vertices_sent;
      while (vertices_sent - start < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)
            send_ellipse($urandom_range(4, 16), 0, $urandom_range(2, 28));
         else if (pick < 75)
            send_scatter($urandom_range(1, 3));
         else if (pick < 88)
            send_scatter($urandom_range(4, 10));
         else if (pick < 96)
            send_collinear($urandom_range(4, 12));
         else
            send_ellipse($urandom_range(17, 48), 0, $urandom_range(8, 28));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, one to three vertices, full-range square,
      // collinear, duplicate and non-convex polygons
      send_vertex(COORD_MIN, COORD_MAX, 1'b1);
      send_vertex(COORD_MIN, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b1);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(COORD_MIN, COORD_MIN, 1'b0);
      send_vertex(0, COORD_MAX, 1'b1);
      send_vertex(COORD_MIN, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b0);
      send_vertex(COORD_MIN, COORD_MAX, 1'b1);
      send_vertex(-3, 1, 1'b0);
      send_vertex(0, 2, 1'b0);
      send_vertex(3, 3, 1'b0);
      send_vertex(6, 4, 1'b1);
      repeat (3) send_vertex(7, -7, 1'b0);
      send_vertex(7, -7, 1'b1);
      send_vertex(0, 0, 1'b0);
      send_vertex(100, 0, 1'b0);
      send_vertex(20, 20, 1'b0);
      send_vertex(100, 100, 1'b0);
      send_vertex(0, 100, 1'b1);

      send_random_polygons(RANDOM_ITEMS / 3);

      // Second phase: idle sender, mostly ready receiver
      send_gap_pct  = 52;
      rsp_stall_pct = 19;
      send_random_polygons(RANDOM_ITEMS / 3);

      // Third phase: no idling
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      send_random_polygons(RANDOM_ITEMS / 3);
      req_valid <= 1'b0;

      // Drain, then watch for stray transfers
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d polygons (%0d vertices): 1 to 3 vertices, convex, collinear,",
               polygons_sent, vertices_sent);
      $display("non-convex and repeated points under three idle mixes; %0d diameters compared",
               checked_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
